// ===== rtl/rtcat_pkg.sv =====
// Shared types and codes for the RTC alarm channel table.
package rtcat_pkg;

    localparam logic [3:0] KIND_TICK      = 4'd0;
    localparam logic [3:0] KIND_NEW_NAME  = 4'd1;
    localparam logic [3:0] KIND_CHECK_IN  = 4'd2;
    localparam logic [3:0] KIND_CHECK_OUT = 4'd3;
    localparam logic [3:0] KIND_SET_ALARM = 4'd4;
    localparam logic [3:0] KIND_CLR_ALARM = 4'd5;
    localparam logic [3:0] KIND_STATUS    = 4'd6;
    localparam logic [3:0] KIND_READ_TIME = 4'd7;
    localparam logic [3:0] KIND_SET_TIME  = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADKIND  = 2'd3;

    localparam int FIRE_LIMIT = 16;

    // Per-slot payload kept in RAM: time, tag, wake, relative.
    localparam int SLOT_W = 66;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [3:0]  slot_index;
        logic [31:0] out_name;
        logic [31:0] out_tag;
        logic        active;
        logic [31:0] alarm_time;
        logic        next_valid;
        logic [31:0] clock_value;
        logic        wake_needed;
        logic        last;
    } result_t;

endpackage

// ===== rtl/rtcat_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module rtcat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rtc_alarm_channel_table.sv =====
// Top level of the RTC alarm channel table: sequencer, slot RAMs, output register.
//
//  channel | group                 | content
//  --------+-----------------------+-------------------------------------------
//  command | s_axis_t*             | tdata: chan_name,time_value,tag,wake_up,
//          |                       |        relative,sleeping ; tuser: kind
//  result  | m_axis_t*             | tdata: status..wake_needed ; tlast: last
//
// One word at a time: s_axis_tready is high only when idle with the result register empty.
// A lookup command runs lookup, then finish; set_time sweeps every slot (one payload read
// per cycle, relative times rewritten in place) before it finishes; a tick runs a due sweep,
// then an earliest-time sweep over every slot. Each fired alarm holds the sweep until m_axis
// takes it.
// Names and armed bits sit in flops cleared by reset; the payload RAM has no reset.
module rtc_alarm_channel_table
    import rtcat_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // chan_name[31:0], time_value[63:32], tag[95:64], wake_up[96],
    // relative[97], sleeping[98], zero[103:99]
    input  logic [103:0] s_axis_tdata,
    // kind[3:0]
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], fired[2], slot_index[6:3], out_name[38:7], out_tag[70:39],
    // active[71], alarm_time[103:72], next_valid[104], clock_value[136:105],
    // wake_needed[137], zero[143:138]
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // sweep slots for tick / set_time
    localparam logic [2:0] S_FIRE = 3'd2;  // wait for fired word to go
    localparam logic [2:0] S_MIN  = 3'd3;  // earliest armed alarm sweep
    localparam logic [2:0] S_DONE = 3'd4;  // finish command, emit final word
    localparam logic [2:0] S_LOOK = 3'd5;  // register name lookup, read hit slot

    logic [2:0]   state_reg;
    logic [3:0]   kind_reg;
    logic [31:0]  name_reg, tval_reg, tag_reg;
    logic         wake_in_reg, rel_in_reg, sleep_reg;
    logic [31:0]  clock_reg;
    logic [31:0]  free_name_reg;
    logic [CW-1:0] ra_reg;              // read address issued
    logic         rv_reg;               // read data valid this cycle
    logic [AW-1:0] rs_reg;              // slot whose data is valid
    logic [SLOTS-1:0] en_reg;           // armed bits
    logic [31:0]  names_reg [SLOTS];    // name per slot
    logic         hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic [31:0]  diff_reg;
    logic         stop_reg, wake_found_reg;
    logic [4:0]   nfire_reg;
    logic         any_reg;
    logic [31:0]  best_reg;
    logic         ob_valid_reg;
    result_t      ob_reg;

    // Payload RAM.
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [SLOT_W-1:0] wdata, rdata;

    rtcat_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    wire [31:0] r_time = rdata[31:0];
    wire [31:0] r_tag  = rdata[63:32];
    wire        r_wake = rdata[64];
    wire        r_rel  = rdata[65];

    assign s_axis_tready = (state_reg == S_IDLE) && !ob_valid_reg;
    wire accept = s_axis_tvalid && s_axis_tready;
    wire ob_free = !ob_valid_reg || m_axis_tready;

    assign m_axis_tvalid = ob_valid_reg;
    assign m_axis_tlast  = ob_reg.last;
    assign m_axis_tdata  = {6'd0, ob_reg.wake_needed, ob_reg.clock_value, ob_reg.next_valid,
                            ob_reg.alarm_time, ob_reg.active, ob_reg.out_tag,
                            ob_reg.out_name, ob_reg.slot_index, ob_reg.fired,
                            ob_reg.status};

    // First free and name lookup: priority search over slot name flops.
    logic         free_any, look_any;
    logic [AW-1:0] free_idx, look_idx;
    always_comb
    begin
        free_any = 1'b0;
        look_any = 1'b0;
        free_idx = '0;
        look_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (names_reg[s] == 32'd0)
            begin
                free_any = 1'b1;
                free_idx = AW'(s);
            end
            if (names_reg[s] == name_reg && name_reg != 32'd0)
            begin
                look_any = 1'b1;
                look_idx = AW'(s);
            end
        end
    end

    // Due test on the returned slot.
    wire due = sleep_reg ? (r_time < clock_reg) : (r_time <= clock_reg);
    wire scan_tick = (kind_reg == KIND_TICK);
    wire cur_en = en_reg[rs_reg];

    // Result words: one per fired alarm, one to finish each command.
    result_t fire_word, done_word;
    always_comb
    begin
        fire_word = '0;
        fire_word.clock_value = clock_reg;
        fire_word.fired = 1'b1;
        fire_word.slot_index = 4'(rs_reg);
        fire_word.out_name = names_reg[rs_reg];
        fire_word.out_tag = r_tag;
        done_word = '0;
        done_word.clock_value = clock_reg;
        done_word.last = 1'b1;
        case (kind_reg)
            KIND_TICK:
            begin
                done_word.next_valid = any_reg;
                done_word.alarm_time = best_reg;
                done_word.wake_needed = wake_found_reg;
            end
            KIND_NEW_NAME:
            begin
                if (free_any)
                begin
                    done_word.out_name = free_name_reg;
                    done_word.slot_index = 4'(free_idx);
                end
                else
                begin
                    done_word.status = ST_FULL;
                end
            end
            KIND_CHECK_IN:
            begin
                if (free_any)
                begin
                    done_word.slot_index = 4'(free_idx);
                end
                else
                begin
                    done_word.status = ST_FULL;
                end
            end
            KIND_CHECK_OUT:
            begin
                if (look_any)
                begin
                    done_word.slot_index = 4'(look_idx);
                end
            end
            KIND_SET_ALARM, KIND_CLR_ALARM, KIND_STATUS:
            begin
                if (!hit_reg)
                begin
                    done_word.status = ST_NOTFOUND;
                end
                else
                begin
                    done_word.slot_index = 4'(hit_slot_reg);
                    if (kind_reg == KIND_STATUS && en_reg[hit_slot_reg])
                    begin
                        done_word.active = 1'b1;
                        done_word.alarm_time = r_time;
                    end
                end
            end
            KIND_READ_TIME:
            begin
            end
            KIND_SET_TIME:
            begin
                done_word.clock_value = tval_reg;
            end
            default:
            begin
                done_word.status = ST_BADKIND;
            end
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = rs_reg;
        wdata = rdata;
        case (state_reg)
            S_IDLE:  raddr = '0;
            S_LOOK:  raddr = look_idx;
            S_DONE:  raddr = hit_slot_reg;
            S_MIN:   raddr = AW'(ra_reg - CW'(1));
            default: raddr = ra_reg[AW-1:0];
        endcase
        if (state_reg == S_SCAN && rv_reg && kind_reg == KIND_SET_TIME
            && cur_en && r_rel)
        begin
            we = 1'b1;
            wdata = {r_rel, r_wake, r_tag, r_time + diff_reg};
        end
        if (state_reg == S_DONE && kind_reg == KIND_SET_ALARM && hit_reg && ob_free)
        begin
            we = 1'b1;
            waddr = hit_slot_reg;
            wdata = {rel_in_reg, wake_in_reg, tag_reg,
                     rel_in_reg ? clock_reg + tval_reg : tval_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_reg      <= 32'd0;
            free_name_reg  <= 32'd2;
            en_reg         <= '0;
            ob_valid_reg   <= 1'b0;
            rv_reg         <= 1'b0;
            ra_reg         <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                names_reg[s] <= 32'd0;
            end
        end
        else
        begin
            if (ob_valid_reg && m_axis_tready)
            begin
                ob_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg    <= s_axis_tuser;
                        name_reg    <= s_axis_tdata[31:0];
                        tval_reg    <= s_axis_tdata[63:32];
                        tag_reg     <= s_axis_tdata[95:64];
                        wake_in_reg <= s_axis_tdata[96];
                        rel_in_reg  <= s_axis_tdata[97];
                        sleep_reg   <= s_axis_tdata[98];
                        diff_reg    <= s_axis_tdata[63:32] - clock_reg;
                        stop_reg    <= 1'b0;
                        wake_found_reg <= 1'b0;
                        nfire_reg   <= '0;
                        any_reg     <= 1'b0;
                        best_reg    <= '0;
                        if (s_axis_tuser == KIND_TICK)
                        begin
                            clock_reg <= clock_reg + 32'd1;
                        end
                        ra_reg <= CW'(1);
                        rv_reg <= 1'b1;
                        rs_reg <= '0;
                        state_reg <= (s_axis_tuser == KIND_TICK
                                      || s_axis_tuser == KIND_SET_TIME) ? S_SCAN : S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    // Hold the hit slot so its payload is on rdata in S_DONE.
                    hit_reg      <= look_any;
                    hit_slot_reg <= look_idx;
                    state_reg    <= S_DONE;
                end
                S_SCAN:
                begin
                    // Advance one slot per cycle; a fire diverts to S_FIRE.
                    if (rv_reg && scan_tick && cur_en && due && !stop_reg)
                    begin
                        if (sleep_reg && r_wake)
                        begin
                            stop_reg <= 1'b1;
                            wake_found_reg <= 1'b1;
                        end
                        else if (nfire_reg < 5'(FIRE_LIMIT))
                        begin
                            state_reg <= S_FIRE;
                            en_reg[rs_reg] <= 1'b0;
                            nfire_reg <= nfire_reg + 5'd1;
                            ob_reg <= fire_word;
                            rv_reg <= 1'b0;
                        end
                    end
                    if (!(rv_reg && scan_tick && cur_en && due && !stop_reg
                          && !(sleep_reg && r_wake) && nfire_reg < 5'(FIRE_LIMIT)))
                    begin
                        if (ra_reg == CW'(SLOTS) || !rv_reg)
                        begin
                            if (ra_reg == CW'(SLOTS))
                            begin
                                rv_reg <= 1'b0;
                                ra_reg <= CW'(1);
                                if (scan_tick)
                                begin
                                    state_reg <= S_MIN;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            else
                            begin
                                rv_reg <= 1'b1;
                                rs_reg <= ra_reg[AW-1:0];
                                ra_reg <= ra_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            rs_reg <= ra_reg[AW-1:0];
                            ra_reg <= ra_reg + CW'(1);
                        end
                    end
                end
                S_FIRE:
                begin
                    // ob_reg loaded; leave once it is taken, re-read next slot.
                    if (!ob_valid_reg)
                    begin
                        ob_valid_reg <= 1'b1;
                    end
                    else if (m_axis_tready)
                    begin
                        state_reg <= S_SCAN;
                        ra_reg <= CW'(rs_reg) + CW'(1);
                        rv_reg <= 1'b0;
                    end
                end
                S_MIN:
                begin
                    // Read address is ra_reg-1; its data comes back the next cycle.
                    if (rv_reg && en_reg[rs_reg] && (!any_reg || r_time < best_reg))
                    begin
                        any_reg <= 1'b1;
                        best_reg <= r_time;
                    end
                    if (ra_reg == CW'(SLOTS) + CW'(1))
                    begin
                        rv_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rv_reg <= 1'b1;
                        rs_reg <= AW'(ra_reg - CW'(1));
                        ra_reg <= ra_reg + CW'(1);
                    end
                end
                S_DONE:
                begin
                    if (ob_free)
                    begin
                        ob_valid_reg <= 1'b1;
                        ob_reg <= done_word;
                        state_reg <= S_IDLE;
                        case (kind_reg)
                            KIND_NEW_NAME:
                            begin
                                free_name_reg <= free_name_reg + 32'd1;
                                if (free_any)
                                begin
                                    names_reg[free_idx] <= free_name_reg;
                                end
                            end
                            KIND_CHECK_IN:
                            begin
                                if (free_any)
                                begin
                                    names_reg[free_idx] <= name_reg;
                                end
                            end
                            KIND_CHECK_OUT:
                            begin
                                if (look_any)
                                begin
                                    names_reg[look_idx] <= 32'd0;
                                    en_reg[look_idx] <= 1'b0;
                                end
                            end
                            KIND_SET_ALARM:
                            begin
                                if (hit_reg)
                                begin
                                    en_reg[hit_slot_reg] <= 1'b1;
                                end
                            end
                            KIND_CLR_ALARM:
                            begin
                                if (hit_reg)
                                begin
                                    en_reg[hit_slot_reg] <= 1'b0;
                                end
                            end
                            KIND_SET_TIME:
                            begin
                                clock_reg <= tval_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rtcat_checker.sv =====
// Port-level checker for the RTC alarm channel table, bound to the top level.
module rtcat_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tlast)
        else $error("fired word marked last");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a word while busy");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[143:138] == 6'd0)
        else $error("pad bits set");

endmodule

bind rtc_alarm_channel_table rtcat_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
